// ----- src/bdc_pkg.sv -----
// Shared constants, types and helpers of the binary cross dilation block.
`default_nettype none

package bdc_pkg;

  // Line buffer and frame limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int PEND_W = $clog2(MAX_WIDTH + 2);

  // Register field widths
  localparam int FW_W  = 11;
  localparam int FH_W  = 13;
  localparam int CFG_W = 13;

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Clamp the written width into 1..MAX_WIDTH
  function automatic logic [FW_W-1:0] clamp_width(input logic [FW_W-1:0] value);
    logic [FW_W-1:0] res;
    if (value == '0) begin
      res = FW_W'(1);
    end else if (value > FW_W'(MAX_WIDTH)) begin
      res = FW_W'(MAX_WIDTH);
    end else begin
      res = value;
    end
    return res;
  endfunction

  // Clamp the written height into 1..MAX_HEIGHT
  function automatic logic [FH_W-1:0] clamp_height(input logic [FH_W-1:0] value);
    logic [FH_W-1:0] res;
    if (value == '0) begin
      res = FH_W'(1);
    end else if (value > FH_W'(MAX_HEIGHT)) begin
      res = FH_W'(MAX_HEIGHT);
    end else begin
      res = value;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- src/bdc_stream_if.sv -----
// Valid/ready stream interfaces for the pixel input and the dilated output.
`default_nettype none

interface bdc_in_if;
  logic valid;
  logic ready;
  logic in_pixel;
  logic flush;

  modport source (output valid, output in_pixel, output flush, input ready);
  modport sink (input valid, input in_pixel, input flush, output ready);
endinterface

interface bdc_out_if;
  logic valid;
  logic ready;
  logic out_pixel;
  logic end_of_row;
  logic end_of_frame;

  modport source (output valid, output out_pixel, output end_of_row,
                  output end_of_frame, input ready);
  modport sink (input valid, input out_pixel, input end_of_row,
                input end_of_frame, output ready);
endinterface

`default_nettype wire

// ----- src/bdc_ram_1r1w.sv -----
// Generic RAM with one write port and one registered read port.
`default_nettype none

module bdc_ram_1r1w #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/bdc_ram_2r1w.sv -----
// Generic RAM with one write port and two registered read ports.
`default_nettype none

module bdc_ram_2r1w #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 1
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Both reads return the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

// ----- src/binary_dilation_cross.sv -----
// Streaming binary dilation with a 4-neighbour cross over two line buffers.
//
// Pixels enter on in_stream in raster order, one beat per pixel; a beat with
// flush set carries no pixel and only drains the oldest pending output.
// Results leave on out_stream with end_of_row / end_of_frame marks. A result
// belongs to the pixel one row plus one pixel before the newest input, so
// the stream trails the input by frame_width + 1 beats; flush beats drain it.
// Throughput is one beat per cycle while the receiver keeps up and the clearing
// pass is done: every beat does its line buffer reads and writes in the cycle it
// is accepted, and its result reaches out_stream through the memory read stage, then the output reg.
// frame_width and frame_height should be written on the cfg port only while idle
// (the block itself does not enforce it); they are clamped into 1..1024 and 1..4096.
// After reset both line buffers are cleared one entry a cycle, and in_ready stays
// low until every entry is cleared; config writes are taken during that pass.
// When the receiver stalls, one result waits in the output register and one
// more in the memory read stage; outside the clearing pass, in_ready drops only when both are full.
`default_nettype none

module binary_dilation_cross (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  bdc_in_if.sink                        in_stream,
  bdc_out_if.source                     out_stream,
  input  wire logic                     cfg_we,
  input  wire logic [0:0]               cfg_index,
  input  wire logic [bdc_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int COL_W  = bdc_pkg::COL_W;
  localparam int ROW_W  = bdc_pkg::ROW_W;
  localparam int PEND_W = bdc_pkg::PEND_W;
  localparam int FW_W   = bdc_pkg::FW_W;
  localparam int FH_W   = bdc_pkg::FH_W;

  // Registers
  logic [FW_W-1:0]   w_r;
  logic [FH_W-1:0]   h_r;
  logic [COL_W:0]    clr_cnt_r;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic [PEND_W-1:0] pend_r, pend_nxt;
  logic [1:0]        cw_r, cw_nxt;
  logic              reload_r, reload_nxt;
  logic              s2_v_r, s2_v_nxt;
  logic              s2_base_r, s2_up_ok_r, s2_dn_ok_r, s2_rt_ok_r, s2_eor_r, s2_eof_r;
  logic              out_v_r, out_v_nxt;
  logic              out_pix_r, out_eor_r, out_eof_r;

  // Combinational
  logic              clr_busy, accept, is_flush, emit, s2_go;
  logic              pend_full, pend_any, pend_two;
  logic              last_col, last_row, in_last_col;
  logic [1:0]        cw_eff;
  logic              centre, left;
  logic [COL_W-1:0]  rc;
  logic              up_q, dn_q, rt_q, s2_pix;
  logic              mid_we, up_we, mid_wdata, up_wdata;
  logic [COL_W-1:0]  mid_waddr, up_waddr;

  assign clr_busy = !clr_cnt_r[COL_W];
  assign s2_go    = !out_v_r || out_stream.ready;
  assign in_stream.ready = !clr_busy && (!s2_v_r || s2_go);
  assign accept   = in_stream.valid && in_stream.ready;
  assign is_flush = in_stream.flush;

  // Pending count against the one-row-plus-one window
  assign pend_full = pend_r > PEND_W'(w_r);
  assign pend_any  = pend_r != '0;
  assign pend_two  = pend_r >= PEND_W'(2);
  assign emit      = accept && (is_flush ? pend_any : pend_full);

  // Centre reload arrives from the right-neighbour read in the cycle after the emit
  assign cw_eff = reload_r ? {cw_r[1], rt_q} : cw_r;
  assign centre = cw_eff[0];
  assign left   = cw_eff[1];

  // Frame position tests
  assign last_col    = (FW_W'(out_col_r) + FW_W'(1)) >= w_r;
  assign last_row    = (FH_W'(out_row_r) + FH_W'(1)) >= h_r;
  assign in_last_col = (FW_W'(in_col_r) + FW_W'(1)) >= w_r;
  assign rc          = last_col ? '0 : out_col_r + COL_W'(1);

  // Advance counters and the cross window
  always_comb begin
    in_col_nxt  = in_col_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    cw_nxt      = cw_eff;
    reload_nxt  = 1'b0;
    if (emit) begin
      if (last_col) begin
        out_col_nxt = '0;
        out_row_nxt = last_row ? '0 : out_row_r + ROW_W'(1);
      end else begin
        out_col_nxt = out_col_r + COL_W'(1);
      end
      cw_nxt     = {centre, 1'b0};
      reload_nxt = pend_two;
    end
    if (accept && !is_flush) begin
      in_col_nxt = in_last_col ? '0 : in_col_r + COL_W'(1);
      if (!pend_any) begin
        cw_nxt[0] = in_stream.in_pixel;
      end
      if (!emit) begin
        pend_nxt = pend_r + PEND_W'(1);
      end
    end else if (emit) begin
      pend_nxt = pend_r - PEND_W'(1);
    end
  end

  // Stage and output valid flags
  always_comb begin
    if (accept) begin
      s2_v_nxt = emit;
    end else if (s2_go) begin
      s2_v_nxt = 1'b0;
    end else begin
      s2_v_nxt = s2_v_r;
    end
    if (s2_v_r && s2_go) begin
      out_v_nxt = 1'b1;
    end else if (out_stream.ready) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  // Line buffer ports; the clearing pass owns the write ports after reset
  assign mid_we    = clr_busy || (accept && !is_flush);
  assign mid_waddr = clr_busy ? clr_cnt_r[COL_W-1:0] : in_col_r;
  assign mid_wdata = clr_busy ? 1'b0 : in_stream.in_pixel;
  assign up_we     = clr_busy || emit;
  assign up_waddr  = clr_busy ? clr_cnt_r[COL_W-1:0] : out_col_r;
  assign up_wdata  = clr_busy ? 1'b0 : centre;

  bdc_ram_2r1w #(
    .DEPTH (bdc_pkg::MAX_WIDTH),
    .WIDTH (1)
  ) u_middle_ram (
    .clk     (clk),
    .we      (mid_we),
    .waddr   (mid_waddr),
    .wdata   (mid_wdata),
    .re      (emit),
    .raddr_a (out_col_r),
    .raddr_b (rc),
    .rdata_a (dn_q),
    .rdata_b (rt_q)
  );

  bdc_ram_1r1w #(
    .DEPTH (bdc_pkg::MAX_WIDTH),
    .WIDTH (1)
  ) u_upper_ram (
    .clk   (clk),
    .we    (up_we),
    .waddr (up_waddr),
    .wdata (up_wdata),
    .re    (emit),
    .raddr (out_col_r),
    .rdata (up_q)
  );

  // Combine the neighbours once the reads return
  assign s2_pix = s2_base_r | (up_q & s2_up_ok_r) | (dn_q & s2_dn_ok_r) | (rt_q & s2_rt_ok_r);

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= bdc_pkg::FW_RESET;
      h_r       <= bdc_pkg::FH_RESET;
      clr_cnt_r <= '0;
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
      cw_r      <= '0;
      reload_r  <= 1'b0;
      s2_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (bdc_pkg::cfg_reg_t'(cfg_index))
          bdc_pkg::CFG_FRAME_WIDTH:  w_r <= bdc_pkg::clamp_width(cfg_wdata[FW_W-1:0]);
          bdc_pkg::CFG_FRAME_HEIGHT: h_r <= bdc_pkg::clamp_height(cfg_wdata[FH_W-1:0]);
          default: ;
        endcase
      end
      if (clr_busy) begin
        clr_cnt_r <= clr_cnt_r + (COL_W+1)'(1);
      end
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
      cw_r      <= cw_nxt;
      reload_r  <= reload_nxt;
      s2_v_r    <= s2_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  // Payload of the read stage and the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      s2_base_r  <= centre | (left & (out_col_r != '0));
      s2_up_ok_r <= out_row_r != '0;
      s2_dn_ok_r <= !last_row && pend_full;
      s2_rt_ok_r <= !last_col && pend_two;
      s2_eor_r   <= last_col;
      s2_eof_r   <= last_col && last_row;
    end
    if (s2_v_r && s2_go) begin
      out_pix_r <= s2_pix;
      out_eor_r <= s2_eor_r;
      out_eof_r <= s2_eof_r;
    end
  end

  assign out_stream.valid        = out_v_r;
  assign out_stream.out_pixel    = out_pix_r;
  assign out_stream.end_of_row   = out_eor_r;
  assign out_stream.end_of_frame = out_eof_r;

endmodule

`default_nettype wire

// ----- src/bdc_checker.sv -----
// Port-level assertions for the dilation block and their bind.
`default_nettype none

module bdc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_pixel,
  input wire logic end_of_row,
  input wire logic end_of_frame
);

  // Hold a stalled result beat and its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) &&
      $stable(end_of_row) && $stable(end_of_frame))
    else $error("stalled result beat changed or dropped");

  // Block input and output right after reset while the line buffers clear
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("beat possible right after reset");

  // A result that appears on an empty output comes from an accepted beat via the read stage
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without an accepted input beat");

endmodule

bind binary_dilation_cross bdc_checker u_bdc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_stream.valid),
  .in_ready     (in_stream.ready),
  .out_valid    (out_stream.valid),
  .out_ready    (out_stream.ready),
  .out_pixel    (out_stream.out_pixel),
  .end_of_row   (out_stream.end_of_row),
  .end_of_frame (out_stream.end_of_frame)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for binary_dilation_cross: queued pixel driver, result monitor and a dilation predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int RANDOM_BEATS = 250;

  localparam int MAX_WIDTH  = bdc_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT = bdc_pkg::MAX_HEIGHT;
  localparam int FW_W       = bdc_pkg::FW_W;
  localparam int FH_W       = bdc_pkg::FH_W;
  localparam int CFG_W      = bdc_pkg::CFG_W;

  typedef struct packed {
    logic pix;
    logic fl;
  } pixel_beat_t;

  typedef struct packed {
    logic px;
    logic eor;
    logic eof;
  } dilated_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  bdc_pkg::cfg_reg_t cfg_index = bdc_pkg::CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]  cfg_wdata = '0;

  bdc_in_if  in_if ();
  bdc_out_if out_if ();

  binary_dilation_cross u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_if),
    .out_stream (out_if),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Predictor state: registers, line buffers, window and frame positions
  logic [FW_W-1:0] fw_reg;
  logic [FH_W-1:0] fh_reg;
  logic            row_above  [MAX_WIDTH];
  logic            row_latest [MAX_WIDTH];
  logic [1:0]      win;
  logic [9:0]      icol, ocol;
  logic [11:0]     irow, orow;
  logic [10:0]     pend;

  pixel_beat_t beat_q[$];
  dilated_t    dilated_q[$];
  int          error_count;
  int          random_pixels;
  int          cycle_count;
  int          in_gap, in_calm, out_stall, out_calm;

  task automatic report_mismatch(input string field, input logic got, input logic want);
    $display("tb: mismatch on %s: got %b, expected %b", field, got, want);
    error_count++;
  endtask

  // Step a raster position, wrapping at the end of a row and of a frame
  function automatic void next_pos(inout logic [9:0] col, inout logic [11:0] row,
                                   input int w, input int h);
    if (int'(col) + 1 >= w) begin
      col = '0;
      row = (int'(row) + 1 >= h) ? '0 : row + 1'b1;
    end else begin
      col = col + 1'b1;
    end
  endfunction

  // Produce the dilated pixel at the output position and advance it
  function automatic void emit_dilated(input int w, input int h);
    int   rc;
    logic ctr, lft, up, dn, rt, last_c, last_r;
    rc     = (int'(ocol) + 1 < w) ? int'(ocol) + 1 : 0;
    ctr    = win[0];
    lft    = win[1];
    up     = row_above[ocol];
    dn     = row_latest[ocol];
    rt     = row_latest[rc];
    last_c = (int'(ocol) + 1 >= w);
    last_r = (int'(orow) + 1 >= h);
    if (ocol == '0) lft = 1'b0;
    if (orow == '0) up = 1'b0;
    if (last_c || pend < 2) rt = 1'b0;
    if (last_r || pend < w + 1) dn = 1'b0;
    dilated_q.push_back('{px: ctr | lft | up | dn | rt, eor: last_c, eof: last_c && last_r});
    row_above[ocol] = ctr;
    next_pos(ocol, orow, w, h);
    pend = pend - 1'b1;
    win = (pend >= 1) ? {ctr, row_latest[ocol]} : {ctr, 1'b0};
  endfunction

  // Update the predictor with one accepted input beat
  function automatic void predict_beat(input logic pix, input logic fl);
    int w, h;
    w = (fw_reg == '0) ? 1 : (fw_reg > MAX_WIDTH) ? MAX_WIDTH : int'(fw_reg);
    h = (fh_reg == '0) ? 1 : (fh_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(fh_reg);
    if (fl) begin
      if (pend >= 1) emit_dilated(w, h);
      return;
    end
    if (pend >= w + 1) emit_dilated(w, h);
    row_latest[icol] = pix;
    if (pend == '0) win = {win[1], pix};
    pend = pend + 1'b1;
    next_pos(icol, irow, w, h);
  endfunction

  // Gap length: mostly none or short, a few long, and stretches with none
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Driver: hold the beat until accepted, then load the next after a gap
  always @(posedge clk) begin
    pixel_beat_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_if.valid && in_if.ready) predict_beat(in_if.in_pixel, in_if.flush);
      if (!in_if.valid || in_if.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (beat_q.size() > 0) begin
          nxt = beat_q.pop_front();
          in_if.valid    <= 1'b1;
          in_if.in_pixel <= nxt.pix;
          in_if.flush    <= nxt.fl;
          in_gap = pick_gap(in_calm);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result beat against the oldest prediction, stall at random
  always @(posedge clk) begin
    dilated_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (dilated_q.size() == 0) begin
          report_mismatch("unexpected result beat", out_if.out_pixel, 1'bx);
        end else begin
          want = dilated_q.pop_front();
          if (out_if.out_pixel !== want.px)
            report_mismatch("out_pixel", out_if.out_pixel, want.px);
          if (out_if.end_of_row !== want.eor)
            report_mismatch("end_of_row", out_if.end_of_row, want.eor);
          if (out_if.end_of_frame !== want.eof)
            report_mismatch("end_of_frame", out_if.end_of_frame, want.eof);
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        out_stall = pick_gap(out_calm);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_beat(input logic pix, input logic fl);
    beat_q.push_back('{pix: pix, fl: fl});
  endtask

  // Queue n pixels, most significant bit first
  task automatic push_pixels(input logic [31:0] bits, input int n);
    for (int i = n - 1; i >= 0; i--) push_beat(bits[i], 1'b0);
  endtask

  task automatic push_flushes(input int n);
    repeat (n) push_beat(1'($urandom_range(0, 1)), 1'b1);
  endtask

  // Wait until no beat is queued, held or expected, then let the pipe settle
  task automatic wait_idle();
    do @(negedge clk);
    while (beat_q.size() != 0 || in_if.valid || dilated_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input bdc_pkg::cfg_reg_t idx, input int value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CFG_W'(value);
    if (idx == bdc_pkg::CFG_FRAME_WIDTH) fw_reg = FW_W'(value);
    else fh_reg = FH_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_frame(input int w, input int h);
    wait_idle();
    write_reg(bdc_pkg::CFG_FRAME_WIDTH, w);
    write_reg(bdc_pkg::CFG_FRAME_HEIGHT, h);
  endtask

  // One random phase: new frame size, whole or partial frames, optional drain
  task automatic random_phase();
    int r, w, h, eff_w, eff_h, n, thresh;
    r = $urandom_range(0, 99);
    w = (r < 70) ? $urandom_range(1, 8) : (r < 92) ? $urandom_range(9, 40) :
        (r < 96) ? 0 : $urandom_range(41, 100);
    r = $urandom_range(0, 99);
    h = (r < 80) ? $urandom_range(1, 6) : (r < 88) ? 0 : (r < 94) ? 8191 : 4096;
    eff_w = (w == 0) ? 1 : w;
    eff_h = (h == 0) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
    wait_idle();
    // upper data bits beyond the width field must be dropped
    write_reg(bdc_pkg::CFG_FRAME_WIDTH, w | ($urandom_range(0, 3) << FW_W));
    write_reg(bdc_pkg::CFG_FRAME_HEIGHT, h);
    n = eff_w * eff_h * $urandom_range(1, 3);
    if (n > 90) n = $urandom_range(20, 90);
    case ($urandom_range(0, 2))
      0: thresh = 10;
      1: thresh = 50;
      default: thresh = 90;
    endcase
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 3) push_flushes(1);
      push_beat(1'($urandom_range(0, 99) < thresh), 1'b0);
      random_pixels++;
    end
    if ($urandom_range(0, 1)) push_flushes(eff_w + 2);
  endtask

  initial begin
    in_if.valid    = 1'b0;
    in_if.in_pixel = 1'b0;
    in_if.flush    = 1'b0;
    out_if.ready   = 1'b0;
    fw_reg = FW_W'(640);
    fh_reg = FH_W'(480);
    for (int i = 0; i < MAX_WIDTH; i++) begin
      row_above[i]  = 1'b0;
      row_latest[i] = 1'b0;
    end
    win  = '0;
    icol = '0;
    irow = '0;
    ocol = '0;
    orow = '0;
    pend = '0;
    error_count   = 0;
    random_pixels = 0;
    cycle_count   = 0;
    in_calm  = 0;
    out_calm = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Reset size: flush with nothing pending, then early flushes
    push_flushes(2);
    push_pixels(4'b1011, 4);
    push_flushes(6);

    // Zero registers clamp to a one-pixel frame
    set_frame(0, 0);
    push_pixels(5'b10011, 5);
    push_flushes(2);

    // One-column frame
    set_frame(1, 4);
    push_pixels(8'b0100_0001, 8);
    push_flushes(3);

    // One-row frame
    set_frame(5, 1);
    push_pixels(10'b10001_00100, 10);
    push_flushes(7);

    // Oversized registers clamp to the largest frame, drained early
    set_frame(2047, 8191);
    repeat (20) push_beat(1'($urandom_range(0, 9) == 0), 1'b0);
    push_flushes(22);

    // Largest legal size, drained early
    set_frame(MAX_WIDTH, MAX_HEIGHT);
    repeat (20) push_beat(1'($urandom_range(0, 1)), 1'b0);
    push_flushes(22);

    // Back-to-back frames left undrained, so the next write lands mid-frame
    set_frame(3, 2);
    push_pixels(12'b100_000_000_001, 12);
    push_pixels(12'b010_111_000_010, 12);

    while (random_pixels < RANDOM_BEATS) random_phase();

    wait_idle();
    repeat (8) @(negedge clk);
    if (error_count == 0 && dilated_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/bdc_pkg.sv
src/bdc_stream_if.sv
src/bdc_ram_1r1w.sv
src/bdc_ram_2r1w.sv
src/binary_dilation_cross.sv
src/bdc_checker.sv
tb/tb_top.sv
